// File: sv/gts_pkg.sv
// Package: constants, codes and table row type of the goodness thread scheduler.
package gts_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 6;
    localparam int TIME_W  = 32;
    localparam int STATE_W = 2;
    localparam int PRIO_W  = 8;
    localparam int SNIP_W  = 10;
    localparam int CFG_W   = 7;

    localparam logic [SNIP_W-1:0] SNIP_MAX = 10'd1023;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PICK  = 2'd2;

    localparam logic [STATE_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [STATE_W-1:0] ST_EXITED  = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] state;
        logic               kernel;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  wakeup;
        logic [SNIP_W-1:0]  snippet;
    } t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

// File: sv/gts_if.sv
// Interfaces: input item channel and result item channel.
interface gts_in_if;
    logic                        valid;
    logic                        ready;
    logic [gts_pkg::MODE_W-1:0]  mode;
    logic [gts_pkg::IDX_W-1:0]   slot_index;
    logic [gts_pkg::TIME_W-1:0]  current_time;
    logic                        slot_valid_in;
    logic [gts_pkg::STATE_W-1:0] slot_state_in;
    logic                        on_kernel_in;
    logic [gts_pkg::PRIO_W-1:0]  priority_in;
    logic [gts_pkg::TIME_W-1:0]  wakeup_in;
    logic [gts_pkg::SNIP_W-1:0]  snippet_in;

    modport source (
        output valid, mode, slot_index, current_time, slot_valid_in, slot_state_in,
               on_kernel_in, priority_in, wakeup_in, snippet_in,
        input  ready
    );
    modport sink (
        input  valid, mode, slot_index, current_time, slot_valid_in, slot_state_in,
               on_kernel_in, priority_in, wakeup_in, snippet_in,
        output ready
    );
endinterface

interface gts_out_if;
    logic                       valid;
    logic                       ready;
    logic [gts_pkg::IDX_W-1:0]  picked_slot;
    logic                       picked_found;
    logic                       all_zero_stuck;
    logic                       resched_flag;

    modport source (
        output valid, picked_slot, picked_found, all_zero_stuck, resched_flag,
        input  ready
    );
    modport sink (
        input  valid, picked_slot, picked_found, all_zero_stuck, resched_flag,
        output ready
    );
endinterface

// File: sv/gts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/goodness_thread_scheduler_top.sv
// Goodness thread scheduler: thread table, tick and pick sequencer.
//
// Input channel i_in (valid/ready) carries one item: a slot write, a tick,
// a pick, or for any other mode a no-op. Output channel o_out returns
// exactly one result item per input item. The scan length comes from the
// active_slots register, to be written through i_cfg_we / i_cfg_wdata only
// while the block is idle; the block itself does not enforce this. The
// table sits in one RAM row per slot; a per-slot written flag, cleared by
// reset, makes never-written rows read as zero, so no clearing pass. Tick
// and pick sweep the first min(active_slots, 64) slots of the table through
// one read-modify-write unit; pick adds a refill sweep when candidates
// exist and all their counters are zero. Each slot passes a read state
// (S_RD) and a process state (S_PROC), as the RAM read data is registered.
// i_in.ready is high only while idle; one item is in work at a time, so a
// new item is taken only once the last one is through.
// The result sits in an output register; while the receiver stalls, a
// new item may be taken and processed, and it waits at its end until the
// register frees. Reset (i_rst_n low, synchronous) empties the table,
// clears active_slots and drops any pending result.
module goodness_thread_scheduler_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    gts_in_if.sink                     i_in,
    gts_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [gts_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import gts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_PROC = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_active;
    logic [MAX_SLOTS-1:0] r_written;
    logic                 r_rd_written;
    logic [MODE_W-1:0]    r_mode;
    logic [TIME_W-1:0]    r_now;
    logic [CNT_W-1:0]     r_len;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_refill, n_refill;
    logic                 r_found, n_found;
    logic [SNIP_W-1:0]    r_best_val, n_best_val;
    logic [SLOT_W-1:0]    r_best_idx, n_best_idx;
    logic                 r_sched, n_sched;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_slot;
    logic                 r_out_found;
    logic                 r_out_stuck;
    logic                 r_out_sched;

    logic                 in_acc;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    t_row                 ram_wdata;
    t_row                 ram_rdata;
    t_row                 cur_row;
    t_row                 new_row;
    logic                 row_wr;
    logic                 cand;
    logic [SNIP_W:0]      refill_sum;
    logic                 out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    gts_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx[SLOT_W-1:0]),
        .o_rdata(ram_rdata)
    );

    assign cur_row    = r_rd_written ? ram_rdata : '0;
    assign refill_sum = {3'b000, cur_row.prio} + {2'b00, cur_row.snippet[SNIP_W-1:1]};

    // read-modify-write unit for one slot
    always_comb begin
        new_row = cur_row;
        row_wr  = 1'b0;
        n_sched = r_sched;
        case (r_mode)
            MODE_TICK: begin
                if (cur_row.valid && cur_row.kernel) begin
                    if (cur_row.snippet == '0) begin
                        n_sched = 1'b1;
                    end else begin
                        new_row.snippet = cur_row.snippet - SNIP_W'(1);
                        row_wr          = 1'b1;
                    end
                end
            end
            MODE_PICK: begin
                if (r_refill) begin
                    if (cur_row.valid) begin
                        new_row.snippet = (refill_sum > {1'b0, SNIP_MAX}) ? SNIP_MAX
                                          : refill_sum[SNIP_W-1:0];
                        row_wr          = 1'b1;
                    end
                end else if (cur_row.valid && cur_row.state != ST_EXITED
                             && r_now > cur_row.wakeup) begin
                    new_row.state = ST_RUNNING;
                    row_wr        = 1'b1;
                end
            end
            default: ;
        endcase
        cand = new_row.valid && !new_row.kernel && new_row.state == ST_RUNNING;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[SLOT_W-1:0];
        ram_wdata = new_row;
        if (r_state == S_IDLE && in_acc && i_in.mode == MODE_WRITE) begin
            ram_we            = 1'b1;
            ram_waddr         = SLOT_W'(i_in.slot_index);
            ram_wdata.valid   = i_in.slot_valid_in;
            ram_wdata.state   = i_in.slot_state_in;
            ram_wdata.kernel  = i_in.on_kernel_in;
            ram_wdata.prio    = i_in.priority_in;
            ram_wdata.wakeup  = i_in.wakeup_in;
            ram_wdata.snippet = i_in.snippet_in;
        end else if (r_state == S_PROC && row_wr) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_refill   = r_refill;
        n_found    = r_found;
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx      = '0;
                    n_refill   = 1'b0;
                    n_found    = 1'b0;
                    n_best_val = '0;
                    n_best_idx = '0;
                    n_state    = (i_in.mode == MODE_TICK || i_in.mode == MODE_PICK) ? S_RD
                                 : S_FIN;
                end
            end
            S_RD: begin
                if (r_idx < r_len) begin
                    n_state = S_PROC;
                end else if (r_mode == MODE_PICK && !r_refill && r_found
                             && r_best_val == '0) begin
                    n_idx      = '0;
                    n_refill   = 1'b1;
                    n_found    = 1'b0;
                    n_best_idx = '0;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PROC: begin
                if (cand && (!r_found || new_row.snippet > r_best_val)) begin
                    n_found    = 1'b1;
                    n_best_val = new_row.snippet;
                    n_best_idx = r_idx[SLOT_W-1:0];
                end
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
            r_sched     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_written[ram_waddr] <= 1'b1;
            end
            if (r_state == S_IDLE && in_acc) begin
                r_sched <= 1'b0;
            end else if (r_state == S_PROC) begin
                r_sched <= n_sched;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_refill     <= n_refill;
        r_found      <= n_found;
        r_best_val   <= n_best_val;
        r_best_idx   <= n_best_idx;
        r_rd_written <= r_written[r_idx[SLOT_W-1:0]];
        if (r_state == S_IDLE && in_acc) begin
            r_mode <= i_in.mode;
            r_now  <= i_in.current_time;
            r_len  <= (32'(r_active) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                      : CNT_W'(r_active);
        end
        if (r_state == S_FIN && out_free) begin
            r_out_found <= r_mode == MODE_PICK && r_found && r_best_val != '0;
            r_out_stuck <= r_mode == MODE_PICK && r_found && r_best_val == '0;
            r_out_sched <= r_mode == MODE_TICK && r_sched;
            r_out_slot  <= (r_mode == MODE_PICK && r_found && r_best_val != '0)
                           ? IDX_W'(r_best_idx) : '0;
        end
    end

    assign i_in.ready            = r_state == S_IDLE;
    assign o_out.valid           = r_out_valid;
    assign o_out.picked_slot     = r_out_slot;
    assign o_out.picked_found    = r_out_found;
    assign o_out.all_zero_stuck  = r_out_stuck;
    assign o_out.resched_flag    = r_out_sched;

endmodule

// File: sv/gts_checker.sv
// Port-level checker for the goodness thread scheduler, with its bind.
module gts_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_found,
    input logic i_stuck,
    input logic i_sched,
    input logic [gts_pkg::IDX_W-1:0] i_slot
);
    import gts_pkg::*;

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_found_xor_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_found && i_stuck) && !((i_found || i_stuck) && i_sched))
        else $error("inconsistent result flags");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_slot == '0)
        else $error("picked slot nonzero without a pick");
endmodule

bind goodness_thread_scheduler_top gts_checker u_gts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_found    (o_out.picked_found),
    .i_stuck    (o_out.all_zero_stuck),
    .i_sched    (o_out.resched_flag),
    .i_slot     (o_out.picked_slot)
);

// File: tb/testbench.sv
// Testbench for goodness_thread_scheduler_top: directed and random items against a table model.
`timescale 1ns / 100ps

module testbench;
    import gts_pkg::*;

    localparam logic [MODE_W-1:0]  MODE_NONE  = 2'd3;
    localparam logic [STATE_W-1:0] ST_WAITING = 2'd0;
    localparam logic [STATE_W-1:0] ST_ODD     = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 600;
    localparam int HOLD_AFTER = 400;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   slot;
        logic [TIME_W-1:0]  now;
        logic               valid;
        logic [STATE_W-1:0] state;
        logic               kernel;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  wakeup;
        logic [SNIP_W-1:0]  snippet;
    } t_sched_item;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic             found;
        logic             stuck;
        logic             sched;
    } t_sched_result;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    gts_in_if  sched_in ();
    gts_out_if sched_out ();

    goodness_thread_scheduler_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (sched_in),
        .o_out       (sched_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // table model
    t_row             thread_tbl [MAX_SLOTS];
    logic [CFG_W-1:0] scan_len_cfg;

    t_sched_item   pending_items [$];
    t_sched_result expected_results [$];
    t_sched_item   offered;
    t_sched_result due;

    int mismatch_count = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    bit long_hold_done = 0;
    int seg_left = 0;
    int seg_kind = 0;

    int phase_span  [10] = '{0, 1, 2, 3, 8, 16, 64, 65, 127, 5};
    int phase_items [10] = '{60, 150, 180, 200, 250, 250, 200, 100, 120, 190};

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic logic find_favorite(input int n, output int idx, output int cnt);
        logic hit = 1'b0;
        idx = 0;
        cnt = 0;
        for (int i = 0; i < n; i++) begin
            if (thread_tbl[i].valid && !thread_tbl[i].kernel && thread_tbl[i].state == ST_RUNNING
                    && (!hit || int'(thread_tbl[i].snippet) > cnt)) begin
                hit = 1'b1;
                cnt = int'(thread_tbl[i].snippet);
                idx = i;
            end
        end
        return hit;
    endfunction

    function automatic t_sched_result schedule_outcome(input t_sched_item it);
        t_sched_result res = '0;
        int n = (int'(scan_len_cfg) < MAX_SLOTS) ? int'(scan_len_cfg) : MAX_SLOTS;
        int best_idx;
        int best_cnt;
        logic [SNIP_W:0] refill;
        case (it.mode)
            MODE_WRITE: begin
                thread_tbl[it.slot] = '{valid: it.valid, state: it.state, kernel: it.kernel,
                                        prio: it.prio, wakeup: it.wakeup, snippet: it.snippet};
            end
            MODE_TICK: begin
                for (int i = 0; i < n; i++) begin
                    if (thread_tbl[i].valid && thread_tbl[i].kernel) begin
                        if (thread_tbl[i].snippet == 0) res.sched = 1'b1;
                        else thread_tbl[i].snippet = thread_tbl[i].snippet - SNIP_W'(1);
                    end
                end
            end
            MODE_PICK: begin
                for (int i = 0; i < n; i++) begin
                    if (thread_tbl[i].valid && thread_tbl[i].state != ST_EXITED
                            && it.now > thread_tbl[i].wakeup)
                        thread_tbl[i].state = ST_RUNNING;
                end
                if (find_favorite(n, best_idx, best_cnt)) begin
                    if (best_cnt == 0) begin
                        for (int i = 0; i < n; i++) begin
                            if (thread_tbl[i].valid) begin
                                refill = thread_tbl[i].prio + (thread_tbl[i].snippet >> 1);
                                thread_tbl[i].snippet = (refill > SNIP_MAX) ? SNIP_MAX
                                                                            : refill[SNIP_W-1:0];
                            end
                        end
                        void'(find_favorite(n, best_idx, best_cnt));
                    end
                    if (best_cnt != 0) begin
                        res.slot  = best_idx[IDX_W-1:0];
                        res.found = 1'b1;
                    end else begin
                        res.stuck = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_sched_item command(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t);
        t_sched_item it = '0;
        it.mode = m;
        it.now  = t;
        return it;
    endfunction

    function automatic t_sched_item slot_write(input int slot, input logic v,
            input logic [STATE_W-1:0] st, input logic k, input logic [PRIO_W-1:0] p,
            input logic [TIME_W-1:0] w, input logic [SNIP_W-1:0] s);
        t_sched_item it = '0;
        it.mode    = MODE_WRITE;
        it.slot    = slot[IDX_W-1:0];
        it.valid   = v;
        it.state   = st;
        it.kernel  = k;
        it.prio    = p;
        it.wakeup  = w;
        it.snippet = s;
        return it;
    endfunction

    function automatic t_sched_item random_item(input int span);
        t_sched_item it;
        int lim = (span == 0 || span > MAX_SLOTS) ? MAX_SLOTS - 1 : span - 1;
        int pick_mode = $urandom_range(0, 99);
        it.mode   = (pick_mode < 50) ? MODE_WRITE : (pick_mode < 65) ? MODE_TICK :
                    (pick_mode < 95) ? MODE_PICK : MODE_NONE;
        it.slot   = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, lim))
                                               : IDX_W'($urandom_range(0, 63));
        it.now    = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 2000) : $urandom;
        it.valid  = ($urandom_range(0, 19) != 0);
        it.state  = STATE_W'($urandom_range(0, 3));
        it.kernel = ($urandom_range(0, 2) == 0);
        it.prio   = ($urandom_range(0, 9) < 3) ? '0 : PRIO_W'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
            0: it.wakeup = $urandom_range(0, 1000);
            1: it.wakeup = $urandom;
            default: it.wakeup = ~$urandom_range(0, 1000);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: it.snippet = '0;
            3, 4: it.snippet = SNIP_W'($urandom_range(0, 3));
            default: it.snippet = SNIP_W'($urandom_range(0, 1023));
        endcase
        return it;
    endfunction

    task automatic set_scan_len(input int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[CFG_W-1:0];
        scan_len_cfg = v[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_items.size() != 0 || sched_in.valid || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            sched_in.valid <= 1'b0;
        end else begin
            if (sched_in.valid && sched_in.ready) begin
                expected_results.push_back(schedule_outcome(offered));
            end
            if (!sched_in.valid || sched_in.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    sched_in.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    offered = pending_items.pop_front();
                    sched_in.mode          <= offered.mode;
                    sched_in.slot_index    <= offered.slot;
                    sched_in.current_time  <= offered.now;
                    sched_in.slot_valid_in <= offered.valid;
                    sched_in.slot_state_in <= offered.state;
                    sched_in.on_kernel_in  <= offered.kernel;
                    sched_in.priority_in   <= offered.prio;
                    sched_in.wakeup_in     <= offered.wakeup;
                    sched_in.snippet_in    <= offered.snippet;
                    sched_in.valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 24);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    sched_in.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            sched_out.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            sched_out.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            sched_out.ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_kind <= $urandom_range(0, 2);
                seg_left <= $urandom_range(1, 80);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_kind)
                0: sched_out.ready <= 1'b1;
                1: sched_out.ready <= ($urandom_range(0, 1) == 1);
                default: sched_out.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && sched_out.valid && sched_out.ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                report_mismatch("result item with nothing pending", 1, 0);
            end else begin
                due = expected_results.pop_front();
                if (sched_out.picked_slot !== due.slot)
                    report_mismatch("picked_slot", sched_out.picked_slot, due.slot);
                if (sched_out.picked_found !== due.found)
                    report_mismatch("picked_found", sched_out.picked_found, due.found);
                if (sched_out.all_zero_stuck !== due.stuck)
                    report_mismatch("all_zero_stuck", sched_out.all_zero_stuck, due.stuck);
                if (sched_out.resched_flag !== due.sched)
                    report_mismatch("resched_flag", sched_out.resched_flag, due.sched);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (sched_in.valid && sched_in.ready) || (sched_out.valid && sched_out.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("goodness_thread_scheduler_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_sched_item ones;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sched_in.valid = 1'b0;
        sched_in.mode = '0;
        sched_in.slot_index = '0;
        sched_in.current_time = '0;
        sched_in.slot_valid_in = 1'b0;
        sched_in.slot_state_in = '0;
        sched_in.on_kernel_in = 1'b0;
        sched_in.priority_in = '0;
        sched_in.wakeup_in = '0;
        sched_in.snippet_in = '0;
        sched_out.ready = 1'b0;
        scan_len_cfg = '0;
        foreach (thread_tbl[i]) thread_tbl[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty scan range after reset
        pending_items.push_back(command(MODE_PICK, '1));
        pending_items.push_back(command(MODE_TICK, '0));
        ones = '1;
        ones.mode = MODE_NONE;
        pending_items.push_back(ones);
        pending_items.push_back(slot_write(63, 1'b1, ST_ODD, 1'b1, '1, '1, '1));
        wait_drained();

        set_scan_len(4);
        pending_items.push_back(slot_write(0, 1'b1, ST_RUNNING, 1'b0, 8'd0, '1, 10'd0));
        pending_items.push_back(command(MODE_PICK, '0));                  // stuck
        pending_items.push_back(slot_write(1, 1'b1, ST_ODD, 1'b0, 8'd255, '0, 10'd1023));
        pending_items.push_back(command(MODE_PICK, 32'd1));               // odd state woken
        pending_items.push_back(slot_write(2, 1'b1, ST_RUNNING, 1'b1, 8'd5, '0, 10'd0));
        pending_items.push_back(command(MODE_TICK, '0));                  // bound slot at zero
        pending_items.push_back(slot_write(2, 1'b1, ST_RUNNING, 1'b1, 8'd5, '0, 10'd2));
        pending_items.push_back(command(MODE_TICK, '0));
        pending_items.push_back(slot_write(1, 1'b1, ST_RUNNING, 1'b0, 8'd255, '0, 10'd0));
        pending_items.push_back(command(MODE_PICK, '0));                  // refill
        pending_items.push_back(slot_write(3, 1'b1, ST_EXITED, 1'b0, 8'd0, '0, 10'd1023));
        pending_items.push_back(command(MODE_PICK, '1));                  // exited not woken
        pending_items.push_back(slot_write(0, 1'b1, ST_RUNNING, 1'b0, 8'd0, '1, 10'd255));
        pending_items.push_back(command(MODE_PICK, '0));                  // tie, low index
        pending_items.push_back(slot_write(0, 1'b0, ST_WAITING, 1'b0, 8'd0, '0, 10'd0));
        pending_items.push_back(command(MODE_PICK, '1));
        pending_items.push_back(slot_write(2, 1'b1, ST_WAITING, 1'b0, 8'd0, 32'h7FFF_FFFF, 10'd0));
        pending_items.push_back(command(MODE_PICK, 32'h7FFF_FFFF));       // wakeup equal to now
        wait_drained();

        foreach (phase_span[p]) begin
            set_scan_len(phase_span[p]);
            repeat (phase_items[p]) pending_items.push_back(random_item(phase_span[p]));
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", expected_results.size(), 0);
        if (mismatch_count == 0)
            $display("goodness_thread_scheduler_top regression: pass");
        else
            $display("goodness_thread_scheduler_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
sv/gts_pkg.sv
sv/gts_if.sv
sv/gts_ram.sv
sv/goodness_thread_scheduler_top.sv
sv/gts_checker.sv
tb/testbench.sv
